>>> rtl/stt_pkg.sv
// Shared types, token codes and keyword table for the source text tokenizer.
// No dependencies.
package stt_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int KW_MAX_LEN_DEF = 6;
    localparam int MAX_RES = 4;
    localparam int Q_DEPTH = 4;
    localparam int NUM_KW = 17;

    localparam logic [5:0] K_DOT = 6'd5;
    localparam logic [5:0] K_BANG = 6'd10;
    localparam logic [5:0] K_EQUAL = 6'd12;
    localparam logic [5:0] K_GREATER = 6'd14;
    localparam logic [5:0] K_LESS = 6'd16;
    localparam logic [5:0] K_SLASH = 6'd18;
    localparam logic [5:0] K_IDENT = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_KEYWORD = 6'd22;
    localparam logic [5:0] K_END = 6'd39;

    localparam logic [1:0] ST_TOKEN = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_OPEN_STR = 2'd2;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_BANG = 3'd1;
    localparam logic [2:0] OP_EQUAL = 3'd2;
    localparam logic [2:0] OP_LESS = 3'd3;
    localparam logic [2:0] OP_GREATER = 3'd4;

    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "and   ", "class ", "else  ", "false ", "for   ", "fun   ", "if    ",
        "nil   ", "or    ", "print ", "return", "super ", "this  ", "true  ",
        "var   ", "while ", "break "
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2,
        4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  status;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
    } t_result;

    typedef struct packed {
        logic [2:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

    function automatic logic [5:0] op_kind(input logic [2:0] op);
        logic [5:0] k;
        case (op)
            OP_BANG:    k = K_BANG;
            OP_EQUAL:   k = K_EQUAL;
            OP_LESS:    k = K_LESS;
            OP_GREATER: k = K_GREATER;
            default:    k = 6'd0;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: byte scanner front end and token queue back end.
// Depends on stt_pkg, stt_front, stt_back.
//
//  Channel  Direction  Handshake                 Payload
//  input    in         i_in_valid / o_in_ready   i_text_byte, i_end_of_text
//  output   out        o_out_valid / i_out_ready token kind, status, offset, length, line, last
//
// One byte is taken per cycle while the bundle queue has room; each byte yields up to
// four tokens, delivered one per cycle from the queue while i_out_ready is high, so output bandwidth sets the rate.
// Reset is synchronous, active low, and returns the scanner to line 1, offset 0.
// Output stalls fill the four-entry queue, after which o_in_ready drops.
module source_text_tokenizer_unit #(
    parameter int POS_BITS = stt_pkg::POS_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_token_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_start_offset,
    output logic [31:0] o_lexeme_length,
    output logic [31:0] o_token_line,
    output logic        o_last_of_run
);
    import stt_pkg::*;

    t_bundle bundle;
    t_result res;
    logic    full, accept;

    assign o_in_ready = !full;
    assign accept = i_in_valid && !full;

    stt_front #(
        .POS_BITS(POS_BITS),
        .KW_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_text_byte(i_text_byte),
        .i_end_of_text(i_end_of_text),
        .i_accept(accept),
        .o_bundle(bundle)
    );

    stt_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(accept && bundle.cnt != 3'd0),
        .i_bundle(bundle),
        .o_full(full),
        .o_result(res),
        .o_last(o_last_of_run),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready)
    );

    assign o_token_kind = res.kind;
    assign o_status = res.status;
    assign o_start_offset = res.start;
    assign o_lexeme_length = res.len;
    assign o_token_line = res.line;

endmodule

>>> rtl/stt_front.sv
// Front end: scans one byte per transaction and builds the bundle of tokens it causes.
// Depends on stt_pkg.
module stt_front #(
    parameter int POS_BITS = stt_pkg::POS_BITS_DEF,
    parameter int KW_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_text,
    input  logic            i_accept,
    output stt_pkg::t_bundle o_bundle
);
    import stt_pkg::*;

    localparam int WL_BITS = $clog2(KW_MAX_LEN + 1);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_OP = 4'd1;
    localparam logic [3:0] M_SLASH = 4'd2;
    localparam logic [3:0] M_COMMENT = 4'd3;
    localparam logic [3:0] M_STRING = 4'd4;
    localparam logic [3:0] M_IDENT = 4'd5;
    localparam logic [3:0] M_INT = 4'd6;
    localparam logic [3:0] M_DOT = 4'd7;
    localparam logic [3:0] M_FRAC = 4'd8;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [KW_MAX_LEN-1:0][7:0] t_word;

    logic [3:0]          r_mode, n_mode;
    logic [2:0]          r_pend, n_pend;
    t_pos                r_ts, n_ts;
    t_pos                r_pos;
    logic [31:0]         r_line, n_line;
    t_word               r_chars, n_chars;
    logic [WL_BITS-1:0]  r_wlen, n_wlen;
    logic                r_tl, n_tl;

    function automatic logic [31:0] sat(input t_pos v);
        if (POS_BITS > 32 && (v >> 32) != '0) return '1;
        return 32'(v);
    endfunction

    function automatic logic [5:0] word_kind(input t_word c, input logic [WL_BITS-1:0] l,
                                             input logic tl);
        logic [5:0] k;
        logic       m;
        k = K_IDENT;
        if (!tl) begin
            for (int w = NUM_KW - 1; w >= 0; w--) begin
                m = (32'(l) == 32'(KW_LEN[w]));
                for (int i = 0; i < 6; i++) begin
                    if (i < 32'(l) && c[i] != KW_TEXT[w][47-8*i -: 8]) m = 1'b0;
                end
                if (m) k = K_KEYWORD + 6'(w);
            end
        end
        return k;
    endfunction

    function automatic t_result mk(input logic [5:0] k, input logic [1:0] s, input t_pos st,
                                   input t_pos ln, input logic [31:0] line);
        t_result r;
        r.kind = k;
        r.status = s;
        r.start = sat(st);
        r.len = sat(ln);
        r.line = line;
        return r;
    endfunction

    logic    is_dig, is_alpha, consumed, line_inc;
    t_pos    p, pinc, e;
    t_result pc [6];
    logic    pv [6];
    t_bundle bnd;

    assign p = r_pos;
    assign pinc = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign e = pinc;
    assign is_dig = (i_text_byte >= "0") && (i_text_byte <= "9");
    assign is_alpha = ((i_text_byte >= "a") && (i_text_byte <= "z")) ||
                      ((i_text_byte >= "A") && (i_text_byte <= "Z")) || (i_text_byte == "_");

    always_comb begin
        n_mode = r_mode;
        n_pend = r_pend;
        n_ts = r_ts;
        n_chars = r_chars;
        n_wlen = r_wlen;
        n_tl = r_tl;
        consumed = 1'b0;
        line_inc = 1'b0;
        for (int j = 0; j < 6; j++) begin
            pv[j] = 1'b0;
            pc[j] = '0;
        end

        // continue the open token
        case (r_mode)
            M_OP: begin
                n_mode = M_IDLE;
                n_pend = OP_NONE;
                pv[0] = 1'b1;
                if (i_text_byte == "=") begin
                    consumed = 1'b1;
                    pc[0] = mk(op_kind(r_pend) + 6'd1, ST_TOKEN, r_ts, t_pos'(2), r_line);
                end else begin
                    pc[0] = mk(op_kind(r_pend), ST_TOKEN, r_ts, t_pos'(1), r_line);
                end
            end
            M_SLASH: begin
                if (i_text_byte == "/") begin
                    n_mode = M_COMMENT;
                    consumed = 1'b1;
                end else begin
                    n_mode = M_IDLE;
                    pv[0] = 1'b1;
                    pc[0] = mk(K_SLASH, ST_TOKEN, r_ts, t_pos'(1), r_line);
                end
            end
            M_COMMENT: begin
                if (i_text_byte != 8'h0a) consumed = 1'b1;
                else n_mode = M_IDLE;
            end
            M_STRING: begin
                consumed = 1'b1;
                if (i_text_byte == "\"") begin
                    n_mode = M_IDLE;
                    pv[0] = 1'b1;
                    pc[0] = mk(K_STRING, ST_TOKEN, r_ts, pinc - r_ts, r_line);
                end else if (i_text_byte == 8'h0a) begin
                    line_inc = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha || is_dig) begin
                    consumed = 1'b1;
                    if (32'(r_wlen) < KW_MAX_LEN) begin
                        for (int i = 0; i < KW_MAX_LEN; i++) begin
                            if (32'(r_wlen) == i) n_chars[i] = i_text_byte;
                        end
                        n_wlen = r_wlen + 1'b1;
                    end else begin
                        n_tl = 1'b1;
                    end
                end else begin
                    n_mode = M_IDLE;
                    pv[0] = 1'b1;
                    pc[0] = mk(word_kind(r_chars, r_wlen, r_tl), ST_TOKEN, r_ts, p - r_ts,
                               r_line);
                end
            end
            M_INT, M_FRAC: begin
                if (is_dig) begin
                    consumed = 1'b1;
                end else if (r_mode == M_INT && i_text_byte == ".") begin
                    consumed = 1'b1;
                    n_mode = M_DOT;
                end else begin
                    n_mode = M_IDLE;
                    pv[0] = 1'b1;
                    pc[0] = mk(K_NUMBER, ST_TOKEN, r_ts, p - r_ts, r_line);
                end
            end
            M_DOT: begin
                if (is_dig) begin
                    consumed = 1'b1;
                    n_mode = M_FRAC;
                end else begin
                    n_mode = M_IDLE;
                    pv[0] = 1'b1;
                    pc[0] = mk(K_NUMBER, ST_TOKEN, r_ts, p - 1'b1 - r_ts, r_line);
                    pv[1] = 1'b1;
                    pc[1] = mk(K_DOT, ST_TOKEN, p - 1'b1, t_pos'(1), r_line);
                end
            end
            default: n_mode = M_IDLE;
        endcase

        // start a new token
        if (!consumed) begin
            pv[2] = 1'b1;
            case (i_text_byte)
                "(": pc[2] = mk(6'd0, ST_TOKEN, p, t_pos'(1), r_line);
                ")": pc[2] = mk(6'd1, ST_TOKEN, p, t_pos'(1), r_line);
                "{": pc[2] = mk(6'd2, ST_TOKEN, p, t_pos'(1), r_line);
                "}": pc[2] = mk(6'd3, ST_TOKEN, p, t_pos'(1), r_line);
                ",": pc[2] = mk(6'd4, ST_TOKEN, p, t_pos'(1), r_line);
                ".": pc[2] = mk(K_DOT, ST_TOKEN, p, t_pos'(1), r_line);
                "-": pc[2] = mk(6'd6, ST_TOKEN, p, t_pos'(1), r_line);
                "+": pc[2] = mk(6'd7, ST_TOKEN, p, t_pos'(1), r_line);
                ";": pc[2] = mk(6'd8, ST_TOKEN, p, t_pos'(1), r_line);
                "*": pc[2] = mk(6'd9, ST_TOKEN, p, t_pos'(1), r_line);
                default: begin
                    pv[2] = 1'b0;
                    n_ts = p;
                    case (i_text_byte)
                        "!": begin n_mode = M_OP; n_pend = OP_BANG; end
                        "=": begin n_mode = M_OP; n_pend = OP_EQUAL; end
                        "<": begin n_mode = M_OP; n_pend = OP_LESS; end
                        ">": begin n_mode = M_OP; n_pend = OP_GREATER; end
                        "/": n_mode = M_SLASH;
                        "\"": n_mode = M_STRING;
                        " ", 8'h09, 8'h0d: ;
                        8'h0a: line_inc = 1'b1;
                        default: begin
                            if (is_dig) begin
                                n_mode = M_INT;
                            end else if (is_alpha) begin
                                n_mode = M_IDENT;
                                n_chars[0] = i_text_byte;
                                n_wlen = WL_BITS'(1);
                                n_tl = 1'b0;
                            end else begin
                                pv[2] = 1'b1;
                                pc[2] = mk(6'd0, ST_BAD_CHAR, p, t_pos'(1), r_line);
                            end
                        end
                    endcase
                end
            endcase
        end

        n_line = (line_inc && r_line != '1) ? r_line + 1'b1 : r_line;

        // end of text: flush and close
        if (i_end_of_text) begin
            pv[3] = 1'b1;
            case (n_mode)
                M_OP:     pc[3] = mk(op_kind(n_pend), ST_TOKEN, n_ts, t_pos'(1), n_line);
                M_SLASH:  pc[3] = mk(K_SLASH, ST_TOKEN, n_ts, t_pos'(1), n_line);
                M_STRING: pc[3] = mk(K_STRING, ST_OPEN_STR, n_ts, e - n_ts, n_line);
                M_IDENT:  pc[3] = mk(word_kind(n_chars, n_wlen, n_tl), ST_TOKEN, n_ts,
                                     e - n_ts, n_line);
                M_INT, M_FRAC: pc[3] = mk(K_NUMBER, ST_TOKEN, n_ts, e - n_ts, n_line);
                M_DOT: begin
                    pc[3] = mk(K_NUMBER, ST_TOKEN, n_ts, p - n_ts, n_line);
                    pv[4] = 1'b1;
                    pc[4] = mk(K_DOT, ST_TOKEN, p, t_pos'(1), n_line);
                end
                default: pv[3] = 1'b0;
            endcase
            pv[5] = 1'b1;
            pc[5] = mk(K_END, ST_TOKEN, e, '0, n_line);
        end
    end

    always_comb begin
        bnd = '0;
        for (int j = 0; j < 6; j++) begin
            if (pv[j] && bnd.cnt < 3'(MAX_RES)) begin
                bnd.res[bnd.cnt[1:0]] = pc[j];
                bnd.cnt = bnd.cnt + 3'd1;
            end
        end
    end

    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= OP_NONE;
            r_ts <= '0;
            r_pos <= '0;
            r_line <= 32'd1;
            r_wlen <= '0;
            r_tl <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_mode <= M_IDLE;
                r_pend <= OP_NONE;
                r_ts <= '0;
                r_pos <= '0;
                r_line <= 32'd1;
                r_wlen <= '0;
                r_tl <= 1'b0;
            end else begin
                r_mode <= n_mode;
                r_pend <= n_pend;
                r_ts <= n_ts;
                r_pos <= pinc;
                r_line <= n_line;
                r_wlen <= n_wlen;
                r_tl <= n_tl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_chars <= n_chars;
    end

endmodule

>>> rtl/stt_back.sv
// Back end: bundle queue and serialiser that delivers one token per transaction.
// Depends on stt_pkg.
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_bundle i_bundle,
    output logic             o_full,
    output stt_pkg::t_result o_result,
    output logic             o_last,
    output logic             o_valid,
    input  logic             i_ready
);
    import stt_pkg::*;

    localparam int PTR_BITS = $clog2(Q_DEPTH);

    t_bundle               r_q [Q_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, r_rd;
    logic [PTR_BITS:0]     r_cnt;
    logic [1:0]            r_idx;
    logic                  pop;
    t_bundle               head;

    assign head = r_q[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full = (r_cnt == (PTR_BITS+1)'(Q_DEPTH));
    assign o_result = head.res[r_idx];
    assign o_last = ({1'b0, r_idx} == head.cnt - 3'd1);
    assign pop = o_valid && i_ready && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_BITS+1)'(i_push) - (PTR_BITS+1)'(pop);
            if (o_valid && i_ready) r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

>>> rtl/stt_checker.sv
// Port-level checks for the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer_unit.
module stt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_token_kind,
    input logic [1:0]  o_status,
    input logic [31:0] o_lexeme_length,
    input logic        o_last_of_run
);
    import stt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind))
        else $error("output transaction dropped while stalled");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_END |-> o_last_of_run && o_lexeme_length == 32'd0)
        else $error("end token not last or non-empty");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OPEN_STR |-> o_token_kind == K_STRING && !o_last_of_run)
        else $error("bad unterminated string result");

    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_BAD_CHAR |-> o_token_kind == 6'd0 &&
        o_lexeme_length == 32'd1)
        else $error("bad unexpected character result");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_token_kind(o_token_kind),
    .o_status(o_status),
    .o_lexeme_length(o_lexeme_length),
    .o_last_of_run(o_last_of_run)
);

>>> bench/source_text_tokenizer_unit_tb.sv
// Testbench for source_text_tokenizer_unit: drives source text bytes with random gaps,
// predicts the token stream in a local scanner model and checks every output transaction.
// Depends on stt_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module source_text_tokenizer_unit_tb;
    import stt_pkg::*;

    typedef enum logic [3:0] {
        SM_IDLE, SM_OP, SM_SLASH, SM_COMMENT, SM_STRING, SM_IDENT, SM_INT, SM_DOT, SM_FRAC
    } t_scan;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } t_byte_item;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  status;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic        last;
    } t_token;

    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_token_kind;
    logic [1:0]  o_status;
    logic [31:0] o_start_offset;
    logic [31:0] o_lexeme_length;
    logic [31:0] o_token_line;
    logic        o_last_of_run;

    source_text_tokenizer_unit u_top (.*);

    t_byte_item text_q[$];
    t_token     token_q[$];
    int         mismatches;
    int         in_idle_pct;
    int         out_idle_pct;
    bit         hold_input;
    bit         stim_done;

    // scanner model state
    t_scan       sc_mode;
    logic [2:0]  sc_op;
    logic [31:0] sc_start;
    logic [31:0] sc_pos;
    logic [31:0] sc_line;
    logic [7:0]  sc_word [KW_MAX_LEN_DEF];
    int          sc_wlen;
    bit          sc_wlong;
    t_token      step_tok[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    task automatic scan_reset();
        sc_mode = SM_IDLE; sc_op = OP_NONE; sc_start = 0; sc_pos = 0; sc_line = 1;
        sc_wlen = 0; sc_wlong = 0;
    endtask

    task automatic push_tok(logic [5:0] k, logic [1:0] s, logic [31:0] st, logic [31:0] l);
        t_token t;
        if (step_tok.size() < MAX_RES) begin
            t = '{k, s, st, l, sc_line, 1'b0};
            step_tok.insert(step_tok.size(), t);
        end
    endtask

    function automatic logic [5:0] word_class();
        bit hit;
        if (sc_wlong) return K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (KW_LEN[k] != sc_wlen) continue;
            hit = 1;
            for (int i = 0; i < sc_wlen; i++)
                if (KW_TEXT[k][47-8*i -: 8] != sc_word[i]) hit = 0;
            if (hit) return K_KEYWORD + 6'(k);
        end
        return K_IDENT;
    endfunction

    task automatic word_add(logic [7:0] b);
        if (sc_wlen < KW_MAX_LEN_DEF) begin
            sc_word[sc_wlen] = b;
            sc_wlen++;
        end else sc_wlong = 1;
    endtask

    function automatic logic [31:0] inc_sat(logic [31:0] v);
        return (v == SAT) ? v : v + 1;
    endfunction

    task automatic start_lexeme(logic [7:0] b, logic [31:0] p);
        string marks;
        marks = "(){},.-+;*";
        for (int i = 0; i < 10; i++)
            if (marks[i] == b) begin
                push_tok(6'(i), ST_TOKEN, p, 1);
                return;
            end
        sc_start = p;
        case (b)
            "!": begin sc_mode = SM_OP; sc_op = OP_BANG; end
            "=": begin sc_mode = SM_OP; sc_op = OP_EQUAL; end
            "<": begin sc_mode = SM_OP; sc_op = OP_LESS; end
            ">": begin sc_mode = SM_OP; sc_op = OP_GREATER; end
            "/": sc_mode = SM_SLASH;
            "\"": sc_mode = SM_STRING;
            " ", "\t", "\r": ;
            "\n": sc_line = inc_sat(sc_line);
            default: begin
                if (is_dig(b)) sc_mode = SM_INT;
                else if (is_alp(b)) begin
                    sc_mode = SM_IDENT; sc_wlen = 0; sc_wlong = 0;
                    word_add(b);
                end else push_tok(6'd0, ST_BAD_CHAR, p, 1);
            end
        endcase
    endtask

    function automatic logic [5:0] op_code(logic [2:0] op);
        case (op)
            OP_BANG:    return K_BANG;
            OP_EQUAL:   return K_EQUAL;
            OP_LESS:    return K_LESS;
            OP_GREATER: return K_GREATER;
            default:    return 6'd0;
        endcase
    endfunction

    task automatic continue_lexeme(logic [7:0] b, logic [31:0] p, output bit used);
        used = 0;
        case (sc_mode)
            SM_OP: begin
                sc_mode = SM_IDLE;
                if (b == "=") begin
                    push_tok(op_code(sc_op) + 6'd1, ST_TOKEN, sc_start, 2);
                    used = 1;
                end else push_tok(op_code(sc_op), ST_TOKEN, sc_start, 1);
                sc_op = OP_NONE;
            end
            SM_SLASH: begin
                if (b == "/") begin sc_mode = SM_COMMENT; used = 1; end
                else begin sc_mode = SM_IDLE; push_tok(K_SLASH, ST_TOKEN, sc_start, 1); end
            end
            SM_COMMENT: begin
                if (b != "\n") used = 1;
                else sc_mode = SM_IDLE;
            end
            SM_STRING: begin
                used = 1;
                if (b == "\"") begin
                    sc_mode = SM_IDLE;
                    push_tok(K_STRING, ST_TOKEN, sc_start, inc_sat(p) - sc_start);
                end else if (b == "\n") sc_line = inc_sat(sc_line);
            end
            SM_IDENT: begin
                if (is_alp(b) || is_dig(b)) begin word_add(b); used = 1; end
                else begin
                    sc_mode = SM_IDLE;
                    push_tok(word_class(), ST_TOKEN, sc_start, p - sc_start);
                end
            end
            SM_INT: begin
                if (is_dig(b)) used = 1;
                else if (b == ".") begin sc_mode = SM_DOT; used = 1; end
                else begin
                    sc_mode = SM_IDLE;
                    push_tok(K_NUMBER, ST_TOKEN, sc_start, p - sc_start);
                end
            end
            SM_DOT: begin
                if (is_dig(b)) begin sc_mode = SM_FRAC; used = 1; end
                else begin
                    sc_mode = SM_IDLE;
                    push_tok(K_NUMBER, ST_TOKEN, sc_start, p - 1 - sc_start);
                    push_tok(K_DOT, ST_TOKEN, p - 1, 1);
                end
            end
            SM_FRAC: begin
                if (is_dig(b)) used = 1;
                else begin
                    sc_mode = SM_IDLE;
                    push_tok(K_NUMBER, ST_TOKEN, sc_start, p - sc_start);
                end
            end
            default: sc_mode = SM_IDLE;
        endcase
    endtask

    task automatic predict_tokens(t_byte_item it);
        logic [31:0] p, e;
        bit used;
        p = sc_pos;
        step_tok.delete();
        continue_lexeme(it.text, p, used);
        if (!used) start_lexeme(it.text, p);
        if (it.eot) begin
            e = inc_sat(p);
            case (sc_mode)
                SM_OP:     push_tok(op_code(sc_op), ST_TOKEN, sc_start, 1);
                SM_SLASH:  push_tok(K_SLASH, ST_TOKEN, sc_start, 1);
                SM_STRING: push_tok(K_STRING, ST_OPEN_STR, sc_start, e - sc_start);
                SM_IDENT:  push_tok(word_class(), ST_TOKEN, sc_start, e - sc_start);
                SM_INT, SM_FRAC: push_tok(K_NUMBER, ST_TOKEN, sc_start, e - sc_start);
                SM_DOT: begin
                    push_tok(K_NUMBER, ST_TOKEN, sc_start, p - sc_start);
                    push_tok(K_DOT, ST_TOKEN, p, 1);
                end
                default: ;
            endcase
            push_tok(K_END, ST_TOKEN, e, 0);
            scan_reset();
        end else sc_pos = inc_sat(p);
        if (step_tok.size() > 0) step_tok[step_tok.size()-1].last = 1'b1;
        foreach (step_tok[i]) token_q.insert(token_q.size(), step_tok[i]);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic add_byte(logic [7:0] b, bit close);
        t_byte_item it;
        it.text = b;
        it.eot = close;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic add_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], close && (i == s.len() - 1));
    endtask

    function automatic string rand_fragment();
        string kws[17];
        string lead, tail, marks, ops, blanks;
        string s;
        int n;
        kws = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                "print", "return", "super", "this", "true", "var", "while", "break"};
        lead = "aZ_q";
        tail = "ab9_Xz0";
        marks = "(){},.-+;*";
        ops = "!=<>";
        blanks = " \t\r\n";
        s = "";
        case ($urandom_range(0, 11))
            0: s = kws[$urandom_range(0, 16)];
            1: begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++) begin
                    if (i == 0) s = {s, string'(lead[$urandom_range(0, 3)])};
                    else s = {s, string'(tail[$urandom_range(0, 6)])};
                end
            end
            2: s = $sformatf("%0d", $urandom_range(0, 9999));
            3: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
            4: s = $sformatf("%0d.", $urandom_range(0, 99));
            5: begin
                if ($urandom_range(0, 1)) s = "\"ab\ncd\"";
                else s = "\"x y\"";
            end
            6: s = string'(marks[$urandom_range(0, 9)]);
            7: begin
                s = string'(ops[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1)) s = {s, "="};
            end
            8: begin
                if ($urandom_range(0, 1)) s = "/ ";
                else s = "// note\n";
            end
            9: s = string'(blanks[$urandom_range(0, 3)]);
            10: s = string'(8'($urandom_range(0, 255)));
            default: s = " ";
        endcase
        return s;
    endfunction

    initial begin
        string s;
        bit close;
        i_rst_n = 1'b0;
        mismatches = 0;
        in_idle_pct = 16;
        out_idle_pct = 16;
        hold_input = 0;
        stim_done = 0;
        scan_reset();
        add_text("(){},.-+;*!!====<<=>>=/x", 0);
        add_text("\"a\nb\" 12.5 3.x @", 0);
        add_byte(8'h00, 0);
        add_byte(8'hFF, 0);
        add_byte(8'h80, 0);
        add_text(" // c\n", 0);
        add_text("returnx breaker while", 1);
        add_text("\"open", 1);
        add_text("7.", 1);
        add_text("<", 1);
        add_text("/", 1);
        add_text("7", 1);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (text_q.size() != 0 || token_q.size() != 0) @(posedge i_clk);
        hold_input = 1;
        repeat (20) @(posedge i_clk);
        hold_input = 0;
        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct = (phase == 1) ? 0 : 16;
            out_idle_pct = (phase == 1) ? 0 : 16;
            for (int n = 0; n < 95;) begin
                s = rand_fragment();
                close = ($urandom_range(0, 15) == 0);
                add_text(s, close);
                n += s.len();
            end
            while (text_q.size() != 0) @(posedge i_clk);
        end
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_text_byte <= 8'd0;
            i_end_of_text <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_tokens('{i_text_byte, i_end_of_text});
                void'(text_q.pop_front());
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (text_q.size() > 0 && !hold_input &&
                    $urandom_range(0, 99) >= in_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_text_byte <= text_q[0].text;
                    i_end_of_text <= text_q[0].eot;
                end else i_in_valid <= 1'b0;
            end
        end
    end

    initial begin
        i_in_valid = 1'b0;
        i_text_byte = 8'd0;
        i_end_of_text = 1'b0;
        i_out_ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_token w;
        if (!i_rst_n) i_out_ready <= 1'b0;
        else begin
            if (o_out_valid && i_out_ready) begin
                if (token_q.size() == 0) begin
                    report("unexpected token", 32'(o_token_kind), 32'd0);
                end else begin
                    w = token_q.pop_front();
                    if (o_token_kind != w.kind)
                        report("kind", 32'(o_token_kind), 32'(w.kind));
                    if (o_status != w.status)
                        report("status", 32'(o_status), 32'(w.status));
                    if (o_start_offset != w.start) report("start", o_start_offset, w.start);
                    if (o_lexeme_length != w.len) report("length", o_lexeme_length, w.len);
                    if (o_token_line != w.line) report("line", o_token_line, w.line);
                    if (o_last_of_run != w.last)
                        report("last", 32'(o_last_of_run), 32'(w.last));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    initial begin
        wait (stim_done);
        while (token_q.size() != 0 || i_in_valid) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && token_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
